// File: hw/rtl/rgbhsv_pkg.sv
// Shared types, constants and divider step functions for the RGB to HSV converter.
// No dependencies.
package rgbhsv_pkg;

    localparam int CHAN_W         = 8;
    localparam int HUE_W          = 15;
    localparam int HUE_QW         = 12;   // hue offset quotient, at most 3840
    localparam int SAT_QW         = 8;    // saturation quotient, at most 255
    localparam int BITS_PER_STAGE = 4;
    localparam int DIV_STAGES     = HUE_QW / BITS_PER_STAGE;
    localparam int SAT_STAGES     = SAT_QW / BITS_PER_STAGE;

    localparam logic [HUE_W-1:0] HUE_BASE_R = 15'd0;
    localparam logic [HUE_W-1:0] HUE_BASE_G = 15'd7680;
    localparam logic [HUE_W-1:0] HUE_BASE_B = 15'd15360;
    localparam logic [HUE_W-1:0] HUE_FULL   = 15'd23040;

    typedef enum logic [1:0] {
        SEC_RED,
        SEC_GREEN,
        SEC_BLUE
    } t_sector;

    // Output of the front stage: maximum, delta, sector and hue difference.
    typedef struct packed {
        logic [CHAN_W-1:0] mx;
        logic [CHAN_W-1:0] delta;
        logic [CHAN_W-1:0] absdiff;
        logic              neg;
        t_sector           sector;
    } t_front;

    // Restoring divider state: nq holds unused numerator bits on top and
    // quotient bits shifting in at the bottom.
    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [HUE_QW-1:0] nq;
        logic [CHAN_W-1:0] d;
    } t_hdiv;

    typedef struct packed {
        logic [CHAN_W-1:0] rem;
        logic [SAT_QW-1:0] nq;
        logic [CHAN_W-1:0] d;
    } t_sdiv;

    typedef struct packed {
        t_hdiv             hdiv;
        t_sdiv             sdiv;
        logic [CHAN_W-1:0] mx;
        logic              neg;
        logic              grey;
        t_sector           sector;
    } t_pipe;

    function automatic t_hdiv hue_stage(input t_hdiv s);
        t_hdiv         o;
        logic [CHAN_W:0] t;
        o = s;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            t = {o.rem, o.nq[HUE_QW-1]};
            if (t >= {1'b0, o.d}) begin
                o.rem = CHAN_W'(t - {1'b0, o.d});
                o.nq  = {o.nq[HUE_QW-2:0], 1'b1};
            end else begin
                o.rem = t[CHAN_W-1:0];
                o.nq  = {o.nq[HUE_QW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

    function automatic t_sdiv sat_stage(input t_sdiv s);
        t_sdiv         o;
        logic [CHAN_W:0] t;
        o = s;
        for (int k = 0; k < BITS_PER_STAGE; k++) begin
            t = {o.rem, o.nq[SAT_QW-1]};
            if (t >= {1'b0, o.d}) begin
                o.rem = CHAN_W'(t - {1'b0, o.d});
                o.nq  = {o.nq[SAT_QW-2:0], 1'b1};
            end else begin
                o.rem = t[CHAN_W-1:0];
                o.nq  = {o.nq[SAT_QW-2:0], 1'b0};
            end
        end
        return o;
    endfunction

endpackage

// File: hw/rtl/rgb_to_hsv_converter.sv
// RGB to HSV converter, top level: front compare stage, pipelined dividers, hue assembly.
// Depends on rgbhsv_pkg.
//
// Usage:
//   Input channel:  i_valid / o_stall, payload i_rgb_color (R 23:16, G 15:8, B 7:0).
//   Output channel: o_valid / i_stall, payload o_hue (1/64 degree), o_saturation,
//                   o_value. A transfer happens on a clock edge with valid high
//                   and stall low.
//   Stages: front stage, numerator stage, three divider stages, output register.
//   Throughput: one transfer per cycle while i_stall stays low. Each divider stage
//   retires four quotient bits of the 12-bit hue division (saturation finishes in two).
//   Every stage has its own valid bit; a stage loads whenever it is empty or
//   the stage after it moves, so bubbles collapse under output stall.
//   When the receiver stalls, the output register holds its payload and the
//   pipeline keeps filling; o_stall rises only once all six stages are full.
//   Reset (synchronous, active low) clears all valid bits; payload registers
//   are not reset. The block keeps no state between colors.
module rgb_to_hsv_converter (
    input  logic                                i_clk,
    input  logic                                i_rst_n,
    input  logic                                i_valid,
    output logic                                o_stall,
    input  logic [23:0]                         i_rgb_color,
    output logic                                o_valid,
    input  logic                                i_stall,
    output logic [rgbhsv_pkg::HUE_W-1:0]        o_hue,
    output logic [rgbhsv_pkg::CHAN_W-1:0]       o_saturation,
    output logic [rgbhsv_pkg::CHAN_W-1:0]       o_value
);
    import rgbhsv_pkg::*;

    localparam int LAST = DIV_STAGES + 2;   // index of the output stage valid

    logic [LAST:0] r_vld;
    logic [LAST:0] rdy;

    t_front n_front, r_front;
    t_pipe  n_pipe [0:DIV_STAGES];
    t_pipe  r_pipe [0:DIV_STAGES];

    logic [HUE_W-1:0]  n_hue, r_hue;
    logic [CHAN_W-1:0] n_sat, r_sat, r_val;

    // ---------------- handshake: per-stage ready chain ----------------
    always_comb begin
        rdy[LAST] = !r_vld[LAST] || !i_stall;
        for (int k = LAST - 1; k >= 0; k--) begin
            rdy[k] = !r_vld[k] || rdy[k+1];
        end
    end

    assign o_stall = !rdy[0];

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_vld <= '0;
        end else begin
            if (rdy[0]) begin
                r_vld[0] <= i_valid;
            end
            for (int k = 1; k <= LAST; k++) begin
                if (rdy[k]) begin
                    r_vld[k] <= r_vld[k-1];
                end
            end
        end
    end

    // ---------------- stage 1: max, min, sector, hue difference ----------------
    always_comb begin
        logic [CHAN_W-1:0] r, g, b, mn, pa, pb;
        r = i_rgb_color[23:16];
        g = i_rgb_color[15:8];
        b = i_rgb_color[7:0];
        n_front.mx = r;
        mn         = r;
        if (g > n_front.mx) n_front.mx = g;
        if (b > n_front.mx) n_front.mx = b;
        if (g < mn) mn = g;
        if (b < mn) mn = b;
        n_front.delta = n_front.mx - mn;
        // first largest channel in red, green, blue order picks the sector
        if (r >= g && r >= b) begin
            n_front.sector = SEC_RED;
            pa = g;
            pb = b;
        end else if (g >= b) begin
            n_front.sector = SEC_GREEN;
            pa = b;
            pb = r;
        end else begin
            n_front.sector = SEC_BLUE;
            pa = r;
            pb = g;
        end
        n_front.neg     = pa < pb;
        n_front.absdiff = n_front.neg ? pb - pa : pa - pb;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[0]) begin
            r_front <= n_front;
        end
    end

    // ---------------- stage 2: numerators, divider seed ----------------
    // Hue numerator |diff|*3840 < delta*4096, so its top byte is already a
    // valid partial remainder; same for 255*delta < mx*256.
    always_comb begin
        logic [CHAN_W+HUE_QW-1:0] hnum;
        logic [CHAN_W+SAT_QW-1:0] snum;
        hnum = ({r_front.absdiff, 12'd0}) - ({4'd0, r_front.absdiff, 8'd0});
        snum = ({r_front.delta, 8'd0}) - ({8'd0, r_front.delta});
        n_pipe[0].hdiv.rem = hnum[CHAN_W+HUE_QW-1:HUE_QW];
        n_pipe[0].hdiv.nq  = hnum[HUE_QW-1:0];
        n_pipe[0].hdiv.d   = r_front.delta;
        n_pipe[0].sdiv.rem = snum[CHAN_W+SAT_QW-1:SAT_QW];
        n_pipe[0].sdiv.nq  = snum[SAT_QW-1:0];
        n_pipe[0].sdiv.d   = r_front.mx;
        n_pipe[0].mx       = r_front.mx;
        n_pipe[0].neg      = r_front.neg;
        n_pipe[0].grey     = (r_front.delta == '0);
        n_pipe[0].sector   = r_front.sector;
    end

    // ---------------- stages 3..5: restoring dividers ----------------
    for (genvar s = 0; s < DIV_STAGES; s++) begin : g_div
        if (s < SAT_STAGES) begin : g_sat
            always_comb begin
                n_pipe[s+1]      = r_pipe[s];
                n_pipe[s+1].hdiv = hue_stage(r_pipe[s].hdiv);
                n_pipe[s+1].sdiv = sat_stage(r_pipe[s].sdiv);
            end
        end else begin : g_hue
            always_comb begin
                n_pipe[s+1]      = r_pipe[s];
                n_pipe[s+1].hdiv = hue_stage(r_pipe[s].hdiv);
            end
        end
    end

    always_ff @(posedge i_clk) begin
        for (int k = 0; k <= DIV_STAGES; k++) begin
            if (rdy[k+1]) begin
                r_pipe[k] <= n_pipe[k];
            end
        end
    end

    // ---------------- stage 6: hue assembly, output register ----------------
    // Only the red sector can go below zero; it wraps by a full turn.
    always_comb begin
        logic [HUE_W-1:0] q, base;
        q = {{(HUE_W-HUE_QW){1'b0}}, r_pipe[DIV_STAGES].hdiv.nq};
        case (r_pipe[DIV_STAGES].sector)
            SEC_GREEN: base = HUE_BASE_G;
            SEC_BLUE:  base = HUE_BASE_B;
            default:   base = HUE_BASE_R;
        endcase
        if (r_pipe[DIV_STAGES].grey) begin
            n_hue = '0;
        end else if (r_pipe[DIV_STAGES].neg && r_pipe[DIV_STAGES].sector == SEC_RED) begin
            n_hue = HUE_FULL - q;
        end else if (r_pipe[DIV_STAGES].neg) begin
            n_hue = base - q;
        end else begin
            n_hue = base + q;
        end
        // black: divisor was zero, quotient is meaningless
        n_sat = (r_pipe[DIV_STAGES].mx == '0) ? '0 : r_pipe[DIV_STAGES].sdiv.nq;
    end

    always_ff @(posedge i_clk) begin
        if (rdy[LAST]) begin
            r_hue <= n_hue;
            r_sat <= n_sat;
            r_val <= r_pipe[DIV_STAGES].mx;
        end
    end

    assign o_valid      = r_vld[LAST];
    assign o_hue        = r_hue;
    assign o_saturation = r_sat;
    assign o_value      = r_val;

    // ---------------- assertions ----------------
    a_grey_hue: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturation == '0 |-> o_hue == '0)
        else $error("grey result with nonzero hue");

    a_hue_range: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid |-> o_hue < HUE_FULL)
        else $error("hue out of range");

    a_sat_value: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_valid && o_saturation != '0 |-> o_value != '0)
        else $error("saturation without value");

    a_full_stall: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        o_stall |-> (&r_vld) && i_stall)
        else $error("input stalled with room in pipeline");

endmodule

// File: dv/tb_top.sv
`timescale 1ns / 100ps
// Self-checking testbench for rgb_to_hsv_converter: directed and random colors
// under several idle/stall mixes, scored against an in-bench HSV predictor.
// Depends on rgbhsv_pkg and the rgb_to_hsv_converter RTL.
module tb_top;

    import rgbhsv_pkg::*;

    localparam int CLK_HALF_NS     = 4;
    localparam int RESET_CYCLES    = 7;
    localparam int HUE_SECTOR_SPAN = 3840;     // 60 degrees in 1/64-degree units
    localparam int PIPE_SETTLE     = 16;       // well past the pipeline latency
    localparam int CYCLE_LIMIT     = 400000;   // watchdog limit on simulated cycles

    // One expected output transfer.
    typedef struct packed {
        logic [HUE_W-1:0]  hue;
        logic [CHAN_W-1:0] saturation;
        logic [CHAN_W-1:0] value;
    } t_hsv;

    // Every input has a known value from time zero.
    logic                 i_clk       = 1'b0;
    logic                 i_rst_n     = 1'b0;
    logic                 i_valid     = 1'b0;
    logic [23:0]          i_rgb_color = '0;
    logic                 i_stall     = 1'b0;
    logic                 o_stall;
    logic                 o_valid;
    logic [HUE_W-1:0]     o_hue;
    logic [CHAN_W-1:0]    o_saturation;
    logic [CHAN_W-1:0]    o_value;

    t_hsv                 hsv_pending[$];   // predicted results, oldest first
    t_hsv                 hsv_head;
    int unsigned          mismatch_count = 0;
    int unsigned          cycle_count    = 0;
    int unsigned          send_idle_pct  = 0;
    int unsigned          recv_stall_pct = 0;

    rgb_to_hsv_converter dut (
        .i_clk        (i_clk),
        .i_rst_n      (i_rst_n),
        .i_valid      (i_valid),
        .o_stall      (o_stall),
        .i_rgb_color  (i_rgb_color),
        .o_valid      (o_valid),
        .i_stall      (i_stall),
        .o_hue        (o_hue),
        .o_saturation (o_saturation),
        .o_value      (o_value)
    );

    always #(CLK_HALF_NS) i_clk = ~i_clk;

    // ------------------------------------------------------------------
    // Predictor: integer HSV, hue offset truncated toward zero, negative
    // hue wrapped by a full turn. Grey and black give hue 0.
    // ------------------------------------------------------------------
    function automatic t_hsv predict_hsv(input logic [23:0] rgb);
        t_hsv    res;
        int      red;
        int      grn;
        int      blu;
        int      top;
        int      bot;
        int      delta;
        int      hue_acc;
        t_sector sec;
        red = int'(rgb[23:16]);
        grn = int'(rgb[15:8]);
        blu = int'(rgb[7:0]);
        top = red;
        bot = red;
        if (grn > top) top = grn;
        if (blu > top) top = blu;
        if (grn < bot) bot = grn;
        if (blu < bot) bot = blu;
        delta = top - bot;
        res.value      = CHAN_W'(top);
        res.saturation = (top != 0) ? CHAN_W'((255 * delta) / top) : '0;
        hue_acc = 0;
        if (res.saturation != 0) begin
            // ties go to the first largest channel: red, then green
            if (red == top) sec = SEC_RED;
            else if (grn == top) sec = SEC_GREEN;
            else sec = SEC_BLUE;
            case (sec)
                SEC_RED: begin
                    hue_acc = int'(HUE_BASE_R) + ((grn - blu) * HUE_SECTOR_SPAN) / delta;
                end
                SEC_GREEN: begin
                    hue_acc = int'(HUE_BASE_G) + ((blu - red) * HUE_SECTOR_SPAN) / delta;
                end
                default: begin
                    hue_acc = int'(HUE_BASE_B) + ((red - grn) * HUE_SECTOR_SPAN) / delta;
                end
            endcase
            if (hue_acc < 0) hue_acc += int'(HUE_FULL);
        end
        res.hue = HUE_W'(hue_acc);
        return res;
    endfunction

    // Random color, biased toward greys, ties, near-greys and channel extremes.
    function automatic logic [23:0] random_color();
        logic [7:0] lvl;
        logic [7:0] alt;
        logic [7:0] edges[4];
        edges = '{8'h00, 8'h01, 8'hFE, 8'hFF};
        lvl = 8'($urandom_range(255));
        alt = 8'($urandom_range(255));
        case ($urandom_range(7))
            4: return {lvl, lvl, lvl};
            5: begin
                case ($urandom_range(2))
                    0: return {lvl, lvl, alt};
                    1: return {alt, lvl, lvl};
                    default: return {lvl, alt, lvl};
                endcase
            end
            6: begin
                // a few codes off grey
                return {lvl ^ 8'($urandom_range(3)), lvl ^ 8'($urandom_range(3)),
                        lvl ^ 8'($urandom_range(3))};
            end
            7: return {edges[$urandom_range(3)], edges[$urandom_range(3)],
                       edges[$urandom_range(3)]};
            default: return 24'($urandom);
        endcase
    endfunction

    // ------------------------------------------------------------------
    // Input side: drive at negedge, transfer seen at posedge with stall low.
    // Valid is only ever written once per negedge.
    // ------------------------------------------------------------------
    task automatic send_color(input logic [23:0] rgb);
        @(negedge i_clk);
        while ($urandom_range(99) < send_idle_pct) begin
            i_valid <= 1'b0;
            @(negedge i_clk);
        end
        i_valid     <= 1'b1;
        i_rgb_color <= rgb;
        @(posedge i_clk);
        while (o_stall !== 1'b0) @(posedge i_clk);
        hsv_pending.push_back(predict_hsv(rgb));
    endtask

    // Sender goes quiet until the pipeline has emptied.
    task automatic wait_for_results();
        @(negedge i_clk);
        i_valid <= 1'b0;
        while (hsv_pending.size() != 0) @(negedge i_clk);
    endtask

    task automatic send_random_colors(input int unsigned count);
        for (int n = 0; n < count; n++) send_color(random_color());
    endtask

    // Output side: random stall, decided at negedge.
    always @(negedge i_clk) begin
        i_stall <= ($urandom_range(99) < recv_stall_pct);
    end

    // Scoreboard: each output transfer against the oldest prediction.
    always @(posedge i_clk) begin
        if (i_rst_n && o_valid === 1'b1 && i_stall == 1'b0) begin
            if (hsv_pending.size() == 0) begin
                $display("%0t: unexpected transfer: expected none, actual hue=%0d sat=%0d val=%0d",
                         $time, o_hue, o_saturation, o_value);
                mismatch_count++;
            end else begin
                hsv_head = hsv_pending.pop_front();
                if (o_hue !== hsv_head.hue) begin
                    $display("%0t: hue mismatch: expected %0d, actual %0d",
                             $time, hsv_head.hue, o_hue);
                    mismatch_count++;
                end
                if (o_saturation !== hsv_head.saturation) begin
                    $display("%0t: saturation mismatch: expected %0d, actual %0d",
                             $time, hsv_head.saturation, o_saturation);
                    mismatch_count++;
                end
                if (o_value !== hsv_head.value) begin
                    $display("%0t: value mismatch: expected %0d, actual %0d",
                             $time, hsv_head.value, o_value);
                    mismatch_count++;
                end
            end
        end
    end

    // Watchdog.
    initial begin
        while (cycle_count < CYCLE_LIMIT) begin
            @(posedge i_clk);
            cycle_count++;
        end
        $display("Regression FAIL");
        $finish;
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------

    // Black, white, greys, primaries, tied maxima, hue wrap, minimum deltas.
    task automatic test_directed_colors();
        logic [23:0] corner[$];
        corner = '{24'h000000, 24'hFFFFFF, 24'h808080, 24'h010101,
                   24'hFF0000, 24'h00FF00, 24'h0000FF,
                   24'hFFFF00, 24'h00FFFF, 24'hFF00FF,   // tied maxima
                   24'hFF0001, 24'hFF00FE, 24'h800001,   // red sector, hue wraps
                   24'h010000, 24'h000001, 24'h000100,
                   24'hFEFFFF, 24'hFFFEFE, 24'h020101,   // smallest deltas
                   24'hFF0080, 24'h80FF00, 24'h0080FF, 24'h7F8081, 24'hAA5533};
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        foreach (corner[k]) send_color(corner[k]);
    endtask

    task automatic test_back_to_back();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_colors(500);
    endtask

    task automatic test_sparse_input();
        send_idle_pct  = 67;
        recv_stall_pct = 0;
        send_random_colors(500);
    endtask

    // Heavy output stall: pipeline fills and input stall is exercised.
    task automatic test_output_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 67;
        send_random_colors(500);
    endtask

    task automatic test_mixed_idle();
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        send_random_colors(300);
    endtask

    // Full drain in the middle of traffic, then resume.
    task automatic test_pause_and_resume();
        send_idle_pct  = 15;
        recv_stall_pct = 15;
        send_random_colors(100);
        wait_for_results();
        send_random_colors(100);
    endtask

    initial begin
        repeat (RESET_CYCLES) @(negedge i_clk);
        i_rst_n <= 1'b1;

        test_directed_colors();
        test_back_to_back();
        test_sparse_input();
        test_output_backpressure();
        test_mixed_idle();
        test_pause_and_resume();

        // drain, then give stray transfers a chance to show up
        recv_stall_pct = 0;
        wait_for_results();
        repeat (PIPE_SETTLE) @(posedge i_clk);

        if (mismatch_count == 0 && hsv_pending.size() == 0) begin
            $display("Regression PASS");
        end else begin
            $display("Regression FAIL");
        end
        $finish;
    end

endmodule

// File: sim.f
hw/rtl/rgbhsv_pkg.sv
hw/rtl/rgb_to_hsv_converter.sv
dv/tb_top.sv
